FILE: rtl/core/peni_pkg.sv
// ----------------------------------------------------------------------------
// peni_pkg
// Shared constants and types for the path/edge nearest intersection block.
// ----------------------------------------------------------------------------
`default_nettype none

package peni_pkg;

  localparam int COORD_WIDTH_DEF   = 16;
  localparam int FRACTION_BITS_DEF = 16;
  localparam int CFG_ADDR_W        = 4;
  localparam longint unsigned INIT_RANGE_RESET = 64'd256000;

  // control word for the shared multiply-accumulate unit
  typedef struct packed {
    logic en;
    logic clr;
    logic neg;
  } peni_mac_op_t;

endpackage

`default_nettype wire

FILE: rtl/core/peni_if.sv
// ----------------------------------------------------------------------------
// peni_if
// Valid/ready channels: edge items in, run results out.
// ----------------------------------------------------------------------------
`default_nettype none

interface peni_in_if #(
  parameter int CW = peni_pkg::COORD_WIDTH_DEF
) ();
  logic                 valid;
  logic                 ready;
  logic signed [CW-1:0] path_start_x;
  logic signed [CW-1:0] path_start_y;
  logic signed [CW-1:0] path_end_x;
  logic signed [CW-1:0] path_end_y;
  logic signed [CW-1:0] edge_start_x;
  logic signed [CW-1:0] edge_start_y;
  logic signed [CW-1:0] edge_end_x;
  logic signed [CW-1:0] edge_end_y;
  logic                 first_edge;
  logic                 last_edge;

  modport source (
    output valid, path_start_x, path_start_y, path_end_x, path_end_y,
           edge_start_x, edge_start_y, edge_end_x, edge_end_y, first_edge, last_edge,
    input  ready
  );
  modport sink (
    input  valid, path_start_x, path_start_y, path_end_x, path_end_y,
           edge_start_x, edge_start_y, edge_end_x, edge_end_y, first_edge, last_edge,
    output ready
  );
endinterface

interface peni_out_if #(
  parameter int CW = peni_pkg::COORD_WIDTH_DEF,
  parameter int RW = 2 * peni_pkg::COORD_WIDTH_DEF + 3
) ();
  logic                 valid;
  logic                 ready;
  logic                 any_hit;
  logic                 nearer_found;
  logic signed [CW-1:0] hit_x;
  logic signed [CW-1:0] hit_y;
  logic [RW-1:0]        hit_range_squared;

  modport source (
    output valid, any_hit, nearer_found, hit_x, hit_y, hit_range_squared,
    input  ready
  );
  modport sink (
    input  valid, any_hit, nearer_found, hit_x, hit_y, hit_range_squared,
    output ready
  );
endinterface

`default_nettype wire

FILE: rtl/core/path_edge_nearest_intersection.sv
// ----------------------------------------------------------------------------
// path_edge_nearest_intersection
// Strict path/edge crossing test with nearest-hit tracking over a run.
// ----------------------------------------------------------------------------
// One edge is taken at a time; in_chan.ready is low while it is worked on.
// An edge that misses passes through the side products on the shared
// multiply-accumulate unit, one decision and one finish step; an edge that
// crosses also passes through the one-bit-per-cycle divider for u and further
// MAC steps for the point and range.
// A run result sits in an output register, so the next edge is taken while it
// waits; initial_range_squared (RANGE_W-bit register, written at any address
// below 8) is loaded at the start of each run.
`default_nettype none

module path_edge_nearest_intersection #(
  parameter  int COORD_WIDTH   = peni_pkg::COORD_WIDTH_DEF,
  parameter  int FRACTION_BITS = peni_pkg::FRACTION_BITS_DEF,
  localparam int RANGE_W       = 2 * COORD_WIDTH + 3,
  localparam int CFG_DW        = ((RANGE_W + 31) / 32) * 32
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  peni_in_if.sink                             in_chan,
  peni_out_if.source                          out_chan,
  input  wire                                 psel,
  input  wire                                 penable,
  input  wire                                 pwrite,
  input  wire  [peni_pkg::CFG_ADDR_W-1:0]     paddr,
  input  wire  [CFG_DW-1:0]                   pwdata,
  output logic [CFG_DW-1:0]                   prdata,
  output logic                                pready
);
  import peni_pkg::*;

  localparam int CW    = COORD_WIDTH;
  localparam int FB    = FRACTION_BITS;
  localparam int DW    = CW + 1;
  localparam int XW    = 2 * CW + 3;
  localparam int NW    = XW + 1;
  localparam int OP_W  = (CW + 2 > FB + 1) ? CW + 2 : FB + 1;
  localparam int ACC_W = 2 * OP_W + 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CROSS,
    S_DECIDE,
    S_DIV,
    S_SCALE,
    S_FINISH
  } state_t;

  state_t state_r;
  logic [3:0] step_r;

  // item registers
  logic signed [CW-1:0] psx_r, psy_r, pex_r, pey_r;
  logic signed [CW-1:0] esx_r, esy_r, eex_r, eey_r;
  logic                 last_r;

  // run state
  logic [RANGE_W-1:0]   init_range_r;
  logic                 hit_seen_r;
  logic                 nearer_seen_r;
  logic [RANGE_W-1:0]   nearest_range_r;
  logic signed [CW-1:0] nearest_x_r, nearest_y_r;

  // side products and hit point
  logic signed [XW-1:0] s1s_r, s1e_r, s2s_r, s2e_r;
  logic signed [CW-1:0] hx_r, hy_r;

  // output register
  logic                 out_valid_r;
  logic                 out_any_r, out_nearer_r;
  logic signed [CW-1:0] out_x_r, out_y_r;
  logic [RANGE_W-1:0]   out_range_r;

  logic signed [DW-1:0] pdx, pdy, edx, edy, ax, ay, bx, by, qx, qy, dx, dy;
  logic [DW-1:0]        edx_mag, edy_mag;
  logic [XW-1:0]        s1s_mag, s1e_mag;
  logic [NW-1:0]        div_den;
  logic                 opp1, opp2, hit;

  peni_mac_op_t            mac_op;
  logic signed [OP_W-1:0]  mul_a, mul_b;
  logic signed [ACC_W-1:0] acc;
  logic signed [OP_W-1:0]  u_op;

  logic                 div_start, div_done;
  logic [FB-1:0]        div_quo;

  logic [CW-1:0]        off;
  logic signed [CW+1:0] off_s, h_sum;
  logic signed [CW-1:0] h_base;
  logic                 h_neg;
  logic [RANGE_W-1:0]   range_new;
  logic                 cfg_wr, out_free;

  always_comb begin
    pdx = DW'(pex_r) - DW'(psx_r);
    pdy = DW'(pey_r) - DW'(psy_r);
    edx = DW'(eex_r) - DW'(esx_r);
    edy = DW'(eey_r) - DW'(esy_r);
    ax  = DW'(esx_r) - DW'(psx_r);
    ay  = DW'(esy_r) - DW'(psy_r);
    bx  = DW'(eex_r) - DW'(psx_r);
    by  = DW'(eey_r) - DW'(psy_r);
    qx  = DW'(pex_r) - DW'(esx_r);
    qy  = DW'(pey_r) - DW'(esy_r);
    dx  = DW'(psx_r) - DW'(hx_r);
    dy  = DW'(psy_r) - DW'(hy_r);
    edx_mag = edx[DW-1] ? DW'(-edx) : DW'(edx);
    edy_mag = edy[DW-1] ? DW'(-edy) : DW'(edy);
    s1s_mag = s1s_r[XW-1] ? XW'(-s1s_r) : XW'(s1s_r);
    s1e_mag = s1e_r[XW-1] ? XW'(-s1e_r) : XW'(s1e_r);
    div_den = NW'(s1s_mag) + NW'(s1e_mag);
    opp1 = (s1s_r != '0) && (s1e_r != '0) && (s1s_r[XW-1] ^ s1e_r[XW-1]);
    opp2 = (s2s_r != '0) && (s2e_r != '0) && (s2s_r[XW-1] ^ s2e_r[XW-1]);
    hit  = opp1 && opp2;
    div_start = (state_r == S_DECIDE) && hit;
    u_op = signed'({{(OP_W-FB){1'b0}}, div_quo});
  end

  // operand schedule for the shared MAC
  always_comb begin
    mac_op = '0;
    mul_a  = '0;
    mul_b  = '0;
    case (state_r)
      S_CROSS: begin
        case (step_r)
          4'd0: begin mul_a = OP_W'(pdx); mul_b = OP_W'(ay); mac_op = '{1'b1, 1'b1, 1'b0}; end
          4'd1: begin mul_a = OP_W'(pdy); mul_b = OP_W'(ax); mac_op = '{1'b1, 1'b0, 1'b1}; end
          4'd2: begin mul_a = OP_W'(pdx); mul_b = OP_W'(by); mac_op = '{1'b1, 1'b1, 1'b0}; end
          4'd3: begin mul_a = OP_W'(pdy); mul_b = OP_W'(bx); mac_op = '{1'b1, 1'b0, 1'b1}; end
          4'd4: begin mul_a = OP_W'(edx); mul_b = OP_W'(ay); mac_op = '{1'b1, 1'b1, 1'b1}; end
          4'd5: begin mul_a = OP_W'(edy); mul_b = OP_W'(ax); mac_op = '{1'b1, 1'b0, 1'b0}; end
          4'd6: begin mul_a = OP_W'(edx); mul_b = OP_W'(qy); mac_op = '{1'b1, 1'b1, 1'b0}; end
          4'd7: begin mul_a = OP_W'(edy); mul_b = OP_W'(qx); mac_op = '{1'b1, 1'b0, 1'b1}; end
          default: ;
        endcase
      end
      S_SCALE: begin
        case (step_r)
          4'd0: begin
            mul_a  = signed'({{(OP_W-DW){1'b0}}, edx_mag});
            mul_b  = u_op;
            mac_op = '{1'b1, 1'b1, 1'b0};
          end
          4'd1: begin
            mul_a  = signed'({{(OP_W-DW){1'b0}}, edy_mag});
            mul_b  = u_op;
            mac_op = '{1'b1, 1'b1, 1'b0};
          end
          4'd4: begin mul_a = OP_W'(dx); mul_b = OP_W'(dx); mac_op = '{1'b1, 1'b1, 1'b0}; end
          4'd5: begin mul_a = OP_W'(dy); mul_b = OP_W'(dy); mac_op = '{1'b1, 1'b0, 1'b0}; end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  // hit point: edge start plus truncated offset
  always_comb begin
    off    = acc[FB+CW-1:FB];
    off_s  = signed'({2'b00, off});
    h_base = (step_r == 4'd2) ? esx_r : esy_r;
    h_neg  = (step_r == 4'd2) ? edx[DW-1] : edy[DW-1];
    h_sum  = (CW+2)'(h_base) + (h_neg ? -off_s : off_s);
    range_new = acc[RANGE_W-1:0];
  end

  peni_mac #(
    .OP_W  (OP_W),
    .ACC_W (ACC_W)
  ) u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .op    (mac_op),
    .a     (mul_a),
    .b     (mul_b),
    .acc   (acc)
  );

  peni_div #(
    .NW (NW),
    .QW (FB)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (NW'(s1s_mag)),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  assign cfg_wr   = psel && penable && pwrite;
  assign pready   = 1'b1;
  assign prdata   = {{(CFG_DW-RANGE_W){1'b0}}, init_range_r};
  assign out_free = !out_valid_r || out_chan.ready;

  assign in_chan.ready          = (state_r == S_IDLE);
  assign out_chan.valid         = out_valid_r;
  assign out_chan.any_hit       = out_any_r;
  assign out_chan.nearer_found  = out_nearer_r;
  assign out_chan.hit_x         = out_x_r;
  assign out_chan.hit_y         = out_y_r;
  assign out_chan.hit_range_squared = out_range_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_IDLE;
      step_r          <= '0;
      init_range_r    <= RANGE_W'(INIT_RANGE_RESET);
      nearest_range_r <= RANGE_W'(INIT_RANGE_RESET);
      hit_seen_r      <= 1'b0;
      nearer_seen_r   <= 1'b0;
      nearest_x_r     <= '0;
      nearest_y_r     <= '0;
      out_valid_r     <= 1'b0;
    end else begin
      if (cfg_wr && !paddr[3]) begin
        init_range_r <= pwdata[RANGE_W-1:0];
      end
      if (out_valid_r && out_chan.ready && !(state_r == S_FINISH && last_r)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_chan.valid) begin
            psx_r  <= in_chan.path_start_x;
            psy_r  <= in_chan.path_start_y;
            pex_r  <= in_chan.path_end_x;
            pey_r  <= in_chan.path_end_y;
            esx_r  <= in_chan.edge_start_x;
            esy_r  <= in_chan.edge_start_y;
            eex_r  <= in_chan.edge_end_x;
            eey_r  <= in_chan.edge_end_y;
            last_r <= in_chan.last_edge;
            if (in_chan.first_edge) begin
              hit_seen_r      <= 1'b0;
              nearer_seen_r   <= 1'b0;
              nearest_range_r <= init_range_r;
              nearest_x_r     <= '0;
              nearest_y_r     <= '0;
            end
            step_r  <= '0;
            state_r <= S_CROSS;
          end
        end
        S_CROSS: begin
          step_r <= step_r + 4'd1;
          case (step_r)
            4'd3: s1s_r <= acc[XW-1:0];
            4'd5: s1e_r <= acc[XW-1:0];
            4'd7: s2s_r <= acc[XW-1:0];
            4'd9: begin
              s2e_r   <= acc[XW-1:0];
              state_r <= S_DECIDE;
            end
            default: ;
          endcase
        end
        S_DECIDE: begin
          state_r <= hit ? S_DIV : S_FINISH;
        end
        S_DIV: begin
          if (div_done) begin
            step_r  <= '0;
            state_r <= S_SCALE;
          end
        end
        S_SCALE: begin
          step_r <= step_r + 4'd1;
          case (step_r)
            4'd2: hx_r <= h_sum[CW-1:0];
            4'd3: hy_r <= h_sum[CW-1:0];
            4'd7: begin
              hit_seen_r <= 1'b1;
              if (range_new < nearest_range_r) begin
                nearest_range_r <= range_new;
                nearest_x_r     <= hx_r;
                nearest_y_r     <= hy_r;
                nearer_seen_r   <= 1'b1;
              end
              state_r <= S_FINISH;
            end
            default: ;
          endcase
        end
        S_FINISH: begin
          if (!last_r) begin
            state_r <= S_IDLE;
          end else if (out_free) begin
            out_valid_r     <= 1'b1;
            out_any_r       <= hit_seen_r;
            out_nearer_r    <= nearer_seen_r;
            out_x_r         <= nearer_seen_r ? nearest_x_r : '0;
            out_y_r         <= nearer_seen_r ? nearest_y_r : '0;
            out_range_r     <= nearer_seen_r ? nearest_range_r : '0;
            hit_seen_r      <= 1'b0;
            nearer_seen_r   <= 1'b0;
            nearest_range_r <= init_range_r;
            nearest_x_r     <= '0;
            nearest_y_r     <= '0;
            state_r         <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/peni_mac.sv
// ----------------------------------------------------------------------------
// peni_mac
// Shared signed multiply-accumulate unit, product registered before the add.
// ----------------------------------------------------------------------------
`default_nettype none

module peni_mac #(
  parameter int OP_W  = 18,
  parameter int ACC_W = 2 * OP_W + 1
) (
  input  wire                       clk,
  input  wire                       rst_n,
  input  peni_pkg::peni_mac_op_t    op,
  input  wire  signed [OP_W-1:0]    a,
  input  wire  signed [OP_W-1:0]    b,
  output logic signed [ACC_W-1:0]   acc
);
  import peni_pkg::*;

  logic signed [2*OP_W-1:0] prod_r;
  peni_mac_op_t             op_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [ACC_W-1:0]  base;
  logic signed [ACC_W-1:0]  prod_ext;
  logic signed [ACC_W-1:0]  acc_nxt;

  always_comb begin
    base     = op_r.clr ? '0 : acc_r;
    prod_ext = ACC_W'(prod_r);
    acc_nxt  = op_r.neg ? base - prod_ext : base + prod_ext;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_r <= '0;
    end else begin
      op_r <= op;
    end
    prod_r <= a * b;
    if (op_r.en) begin
      acc_r <= acc_nxt;
    end
  end

  assign acc = acc_r;

endmodule

`default_nettype wire

FILE: rtl/core/peni_div.sv
// ----------------------------------------------------------------------------
// peni_div
// Restoring fraction divider: quo = floor(num * 2^QW / den), num < den.
// ----------------------------------------------------------------------------
`default_nettype none

module peni_div #(
  parameter int NW = 36,
  parameter int QW = 16
) (
  input  wire           clk,
  input  wire           rst_n,
  input  wire           start,
  input  wire  [NW-1:0] num,
  input  wire  [NW-1:0] den,
  output logic          done,
  output logic [QW-1:0] quo
);
  import peni_pkg::*;

  localparam int CNT_W = $clog2(QW + 1);

  logic [NW-1:0]    rem_r;
  logic [NW-1:0]    den_r;
  logic [QW-1:0]    quo_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [NW:0]      rem2;
  logic [NW:0]      rem_sub;
  logic             ge;

  always_comb begin
    rem2    = {rem_r, 1'b0};
    ge      = rem2 >= {1'b0, den_r};
    rem_sub = rem2 - {1'b0, den_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        rem_r  <= num;
        den_r  <= den;
        cnt_r  <= CNT_W'(QW);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        rem_r <= ge ? rem_sub[NW-1:0] : rem2[NW-1:0];
        quo_r <= {quo_r[QW-2:0], ge};
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

`default_nettype wire
